### hw/rtl/smfx_pkg.sv
// ----------------------------------------------------------------------------
// smfx_pkg
// Shared codes, widths and stage payload types for the sign-magnitude
// 64.64 fixed-point ALU pipeline.
// ----------------------------------------------------------------------------
package smfx_pkg;

  localparam int FieldW = 64;
  localparam int MagW   = 2 * FieldW;

  // request codes
  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_SUB    = 3'd1;
  localparam logic [2:0] OP_NEG    = 3'd2;
  localparam logic [2:0] OP_HALVE  = 3'd3;
  localparam logic [2:0] OP_DOUBLE = 3'd4;
  localparam logic [2:0] OP_CMP    = 3'd5;

  // status codes
  localparam logic [2:0] ST_POS     = 3'd0;
  localparam logic [2:0] ST_NEG     = 3'd1;
  localparam logic [2:0] ST_ERR     = 3'd2;
  localparam logic [2:0] ST_OVF_NEG = 3'd3;
  localparam logic [2:0] ST_OVF_POS = 3'd4;
  localparam logic [2:0] ST_UNF_NEG = 3'd5;
  localparam logic [2:0] ST_UNF_POS = 3'd6;

  // compare order codes
  localparam logic signed [1:0] ORD_LT = -2'sd1;
  localparam logic signed [1:0] ORD_EQ = 2'sd0;
  localparam logic signed [1:0] ORD_GT = 2'sd1;

  typedef enum logic [2:0] {
    K_SUM   = 3'd0,
    K_NEG   = 3'd1,
    K_HALVE = 3'd2,
    K_CMP   = 3'd3,
    K_ERR   = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic              a_neg;
    logic              b_neg;
    logic [MagW-1:0]   a_mag;
    logic [MagW-1:0]   b_mag;
  } prep_t;

  typedef struct packed {
    kind_t             kind;
    logic              a_neg;
    logic              b_neg;
    logic              a_zero;
    logic              b_zero;
    logic              eq;
    logic [MagW:0]     sum;
    logic [MagW:0]     dab;
    logic [MagW-1:0]   dba;
    logic [MagW-1:0]   a_mag;
  } arith_t;

endpackage

### hw/rtl/smfx_prep.sv
// ----------------------------------------------------------------------------
// smfx_prep
// Stage 1: operand check, request decode and effective operand signs.
// ----------------------------------------------------------------------------
module smfx_prep import smfx_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [2:0]        in_req_type,
  input  logic [FieldW-1:0] in_left_whole,
  input  logic [FieldW-1:0] in_left_frac,
  input  logic [2:0]        in_left_status,
  input  logic [FieldW-1:0] in_right_whole,
  input  logic [FieldW-1:0] in_right_frac,
  input  logic [2:0]        in_right_status,
  input  logic              take,
  output logic              ready,
  output logic              valid_r,
  output prep_t             prep_r
);

  prep_t           prep_nxt;
  logic            l_ok;
  logic            r_ok;
  logic            needs_r;
  logic            l_neg;
  logic            r_neg;
  logic [MagW-1:0] l_mag;
  logic [MagW-1:0] r_mag;
  logic            r_zero;

  assign ready = !valid_r || take;

  always_comb begin
    l_ok    = (in_left_status == ST_POS) || (in_left_status == ST_NEG);
    r_ok    = (in_right_status == ST_POS) || (in_right_status == ST_NEG);
    needs_r = (in_req_type == OP_ADD) || (in_req_type == OP_SUB) || (in_req_type == OP_CMP);
    l_neg   = (in_left_status == ST_NEG);
    r_neg   = (in_right_status == ST_NEG);
    l_mag   = {in_left_whole, in_left_frac};
    r_mag   = {in_right_whole, in_right_frac};
    r_zero  = (r_mag == '0);

    prep_nxt.kind  = K_ERR;
    prep_nxt.a_neg = l_neg;
    prep_nxt.b_neg = r_neg;
    prep_nxt.a_mag = l_mag;
    prep_nxt.b_mag = r_mag;

    unique case (in_req_type)
      OP_ADD: begin
        prep_nxt.kind = K_SUM;
      end
      OP_SUB: begin
        prep_nxt.kind  = K_SUM;
        // negating a zero keeps its sign
        prep_nxt.b_neg = r_zero ? r_neg : !r_neg;
      end
      OP_NEG: begin
        prep_nxt.kind = K_NEG;
      end
      OP_HALVE: begin
        prep_nxt.kind = K_HALVE;
      end
      OP_DOUBLE: begin
        prep_nxt.kind  = K_SUM;
        prep_nxt.b_neg = l_neg;
        prep_nxt.b_mag = l_mag;
      end
      OP_CMP: begin
        prep_nxt.kind = K_CMP;
      end
      default: begin
        prep_nxt.kind = K_ERR;
      end
    endcase

    if (!l_ok || (needs_r && !r_ok)) begin
      prep_nxt.kind = K_ERR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && in_valid) begin
      prep_r <= prep_nxt;
    end
  end

endmodule

### hw/rtl/smfx_arith.sv
// ----------------------------------------------------------------------------
// smfx_arith
// Stage 2: 128-bit magnitude sum, both differences and zero/equal flags.
// ----------------------------------------------------------------------------
module smfx_arith import smfx_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   up_valid,
  input  prep_t  up_data,
  input  logic   take,
  output logic   ready,
  output logic   valid_r,
  output arith_t arith_r
);

  arith_t arith_nxt;

  assign ready = !valid_r || take;

  always_comb begin
    arith_nxt.kind   = up_data.kind;
    arith_nxt.a_neg  = up_data.a_neg;
    arith_nxt.b_neg  = up_data.b_neg;
    arith_nxt.a_zero = (up_data.a_mag == '0);
    arith_nxt.b_zero = (up_data.b_mag == '0);
    arith_nxt.eq     = (up_data.a_mag == up_data.b_mag);
    arith_nxt.sum    = {1'b0, up_data.a_mag} + {1'b0, up_data.b_mag};
    arith_nxt.dab    = {1'b0, up_data.a_mag} - {1'b0, up_data.b_mag};
    arith_nxt.dba    = up_data.b_mag - up_data.a_mag;
    arith_nxt.a_mag  = up_data.a_mag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && up_valid) begin
      arith_r <= arith_nxt;
    end
  end

endmodule

### hw/rtl/smfx_resolve.sv
// ----------------------------------------------------------------------------
// smfx_resolve
// Stage 3: result selection, status and compare order, output register.
// ----------------------------------------------------------------------------
module smfx_resolve import smfx_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  input  arith_t              up_data,
  input  logic                out_stall,
  output logic                ready,
  output logic                out_valid,
  output logic [FieldW-1:0]   out_result_whole,
  output logic [FieldW-1:0]   out_result_frac,
  output logic [2:0]          out_result_status,
  output logic signed [1:0]   out_order
);

  logic               valid_r;
  logic [MagW-1:0]    mag_r;
  logic [2:0]         status_r;
  logic signed [1:0]  order_r;
  logic [MagW-1:0]    mag_nxt;
  logic [2:0]         status_nxt;
  logic signed [1:0]  order_nxt;
  logic               ge;
  logic               sign;

  assign ready = !valid_r || !out_stall;
  assign ge    = !up_data.dab[MagW];
  assign sign  = up_data.a_neg;

  always_comb begin
    mag_nxt    = '0;
    status_nxt = ST_POS;
    order_nxt  = ORD_EQ;
    unique case (up_data.kind)
      K_SUM: begin
        if (up_data.a_neg == up_data.b_neg) begin
          mag_nxt = up_data.sum[MagW-1:0];
          if (up_data.sum[MagW]) begin
            status_nxt = sign ? ST_OVF_NEG : ST_OVF_POS;
          end else begin
            status_nxt = sign ? ST_NEG : ST_POS;
          end
        end else begin
          mag_nxt = ge ? up_data.dab[MagW-1:0] : up_data.dba;
          if (up_data.eq) begin
            status_nxt = ST_POS;
          end else begin
            status_nxt = (ge ? up_data.a_neg : up_data.b_neg) ? ST_NEG : ST_POS;
          end
        end
      end
      K_NEG: begin
        mag_nxt = up_data.a_mag;
        if (up_data.a_zero) begin
          status_nxt = sign ? ST_NEG : ST_POS;
        end else begin
          status_nxt = sign ? ST_POS : ST_NEG;
        end
      end
      K_HALVE: begin
        mag_nxt = {1'b0, up_data.a_mag[MagW-1:1]};
        if (up_data.a_mag[0]) begin
          status_nxt = sign ? ST_UNF_NEG : ST_UNF_POS;
        end else begin
          status_nxt = sign ? ST_NEG : ST_POS;
        end
      end
      K_CMP: begin
        if (up_data.a_neg != up_data.b_neg) begin
          if (up_data.a_zero && up_data.b_zero) begin
            order_nxt = ORD_EQ;
          end else begin
            order_nxt = sign ? ORD_LT : ORD_GT;
          end
        end else if (up_data.eq) begin
          order_nxt = ORD_EQ;
        end else begin
          order_nxt = (ge ^ sign) ? ORD_GT : ORD_LT;
        end
      end
      default: begin
        status_nxt = ST_ERR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && up_valid) begin
      mag_r    <= mag_nxt;
      status_r <= status_nxt;
      order_r  <= order_nxt;
    end
  end

  assign out_valid         = valid_r;
  assign out_result_whole  = mag_r[MagW-1:FieldW];
  assign out_result_frac   = mag_r[FieldW-1:0];
  assign out_result_status = status_r;
  assign out_order         = order_r;

endmodule

### hw/rtl/sign_magnitude_fixed_point_alu_core.sv
// ----------------------------------------------------------------------------
// sign_magnitude_fixed_point_alu_core
// Sign-magnitude 64.64 fixed-point ALU: add, subtract, negate, halve,
// double and three-way compare over a three-stage pipeline.
// ----------------------------------------------------------------------------
// an accepted request moves through the prep, arith and resolve registers to out_valid
// throughput: one request per cycle while out_stall is low; each stage holds one request
// the 128-bit add/subtract stage sits between decode and result select
// reset: synchronous rst_n clears every stage valid bit, payload is not reset
module sign_magnitude_fixed_point_alu_core import smfx_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          in_req_type,
  input  logic [FieldW-1:0]   in_left_whole,
  input  logic [FieldW-1:0]   in_left_frac,
  input  logic [2:0]          in_left_status,
  input  logic [FieldW-1:0]   in_right_whole,
  input  logic [FieldW-1:0]   in_right_frac,
  input  logic [2:0]          in_right_status,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [FieldW-1:0]   out_result_whole,
  output logic [FieldW-1:0]   out_result_frac,
  output logic [2:0]          out_result_status,
  output logic signed [1:0]   out_order
);

  logic   prep_ready;
  logic   prep_valid;
  prep_t  prep_data;
  logic   arith_ready;
  logic   arith_valid;
  arith_t arith_data;
  logic   res_ready;

  assign in_stall = !prep_ready;

  smfx_prep u_prep (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_req_type     (in_req_type),
    .in_left_whole   (in_left_whole),
    .in_left_frac    (in_left_frac),
    .in_left_status  (in_left_status),
    .in_right_whole  (in_right_whole),
    .in_right_frac   (in_right_frac),
    .in_right_status (in_right_status),
    .take            (arith_ready),
    .ready           (prep_ready),
    .valid_r         (prep_valid),
    .prep_r          (prep_data)
  );

  smfx_arith u_arith (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (prep_valid),
    .up_data  (prep_data),
    .take     (res_ready),
    .ready    (arith_ready),
    .valid_r  (arith_valid),
    .arith_r  (arith_data)
  );

  smfx_resolve u_resolve (
    .clk               (clk),
    .rst_n             (rst_n),
    .up_valid          (arith_valid),
    .up_data           (arith_data),
    .out_stall         (out_stall),
    .ready             (res_ready),
    .out_valid         (out_valid),
    .out_result_whole  (out_result_whole),
    .out_result_frac   (out_result_frac),
    .out_result_status (out_result_status),
    .out_order         (out_order)
  );

`ifndef SYNTHESIS
  a_order_only_cmp : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_order != ORD_EQ) |->
      (out_result_status == ST_POS) && (out_result_whole == '0) && (out_result_frac == '0))
    else $error("nonzero order on a non-compare result");

  a_order_code : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_order != 2'sb10))
    else $error("illegal order code");

  a_err_clean : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_status == ST_ERR) |->
      (out_result_whole == '0) && (out_result_frac == '0) && (out_order == ORD_EQ))
    else $error("error result carries data");

  a_empty_accepts : assert property (@(posedge clk) disable iff (!rst_n)
    !prep_valid |-> !in_stall)
    else $error("input stalled with an empty first stage");

  a_stage2_holds : assert property (@(posedge clk) disable iff (!rst_n)
    arith_valid && !res_ready |=> arith_valid && $stable(arith_data))
    else $error("stalled stage 2 request lost or changed");
`endif

endmodule
